/* rtl/object_table_with_aabb_query_unit_defines.svh */
// assertion macros for the object table checker
// no dependencies
`ifndef OBJECT_TABLE_WITH_AABB_QUERY_UNIT_DEFINES_SVH
`define OBJECT_TABLE_WITH_AABB_QUERY_UNIT_DEFINES_SVH
// implication checked on every clock outside reset
`define OT_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define OT_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* rtl/otaq_pkg.sv */
// shared types and constants for the object table
// no dependencies
package otaq_pkg;
  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  localparam logic [1:0] REQ_SPAWN = 2'd0;
  localparam logic [1:0] REQ_KILL = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // one stored table row
  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] kind;
    logic solid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0] size_x;
    logic [30:0] size_y;
    logic [30:0] size_z;
  } entry_t;

  // strict overlap of [qa, qa+qs) and [ea, ea+es) on one axis
  function automatic logic axis_hit(logic signed [31:0] qa, logic [30:0] qs,
                                    logic signed [31:0] ea, logic [30:0] es);
    logic signed [33:0] q0;
    logic signed [33:0] e0;
    q0 = 34'(qa);
    e0 = 34'(ea);
    return (q0 < e0 + $signed({3'b0, es})) && (q0 + $signed({3'b0, qs}) > e0);
  endfunction
endpackage

/* rtl/otaq_mem.sv */
// entry storage: one write port, one registered read port
// depends on otaq_pkg
module otaq_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [otaq_pkg::IdxW-1:0]   waddr,
  input  otaq_pkg::entry_t            wdata,
  input  logic [otaq_pkg::IdxW-1:0]   raddr,
  output otaq_pkg::entry_t            rdata
);
  otaq_pkg::entry_t mem [otaq_pkg::Capacity];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/otaq_match.sv */
// compare unit: handle match, and box overlap with one solid row of another handle
// depends on otaq_pkg
module otaq_match (
  input  otaq_pkg::entry_t   ent,
  input  otaq_pkg::entry_t   req,
  output logic               handle_eq,
  output logic               overlap
);
  // per-row test applied at each step of the scan
  always_comb begin
    handle_eq = (ent.handle == req.handle);
    overlap = ent.solid && !handle_eq &&
              otaq_pkg::axis_hit(req.pos_x, req.size_x, ent.pos_x, ent.size_x) &&
              otaq_pkg::axis_hit(req.pos_y, req.size_y, ent.pos_y, ent.size_y) &&
              otaq_pkg::axis_hit(req.pos_z, req.size_z, ent.pos_z, ent.size_z);
  end
endmodule

/* rtl/object_table_with_aabb_query_unit.sv */
// Object table with box overlap query, top level.
// Spawn: result offered in the cycle after the transfer. Kill, lookup, query:
// live entries are scanned in turn through the single memory read port, result
// offered after the matching or last row is tested (kill then moves the last row
// into the killed slot through S_MOVE and S_PUT); back to idle before the next transfer.
// One request at a time. Reset clears live count to 0 and next handle to 1;
// table contents stay undefined until written.
module object_table_with_aabb_query_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_handle,
  input  logic [31:0] in_kind,
  input  logic        in_solid,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [30:0] in_size_x,
  input  logic [30:0] in_size_y,
  input  logic [30:0] in_size_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_out_handle,
  output logic        out_hit,
  output logic [31:0] out_out_kind,
  output logic        out_out_solid,
  output logic signed [31:0] out_out_pos_x,
  output logic signed [31:0] out_out_pos_y,
  output logic signed [31:0] out_out_pos_z,
  output logic [30:0] out_out_size_x,
  output logic [30:0] out_out_size_y,
  output logic [30:0] out_out_size_z,
  output logic [6:0]  out_live_count
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_TEST = 6'b000100,
    S_MOVE = 6'b001000,
    S_PUT  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam int IW = otaq_pkg::IdxW;
  localparam int CW = otaq_pkg::CntW;

  state_t state_r, state_nxt;
  otaq_pkg::entry_t req_r;
  logic [1:0] type_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [31:0] next_h_r, next_h_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;   // read address issued
  logic [IW-1:0] slot_r, slot_nxt; // address of row at rdata in S_TEST; killed slot in S_MOVE and S_PUT
  logic [1:0] st_r, st_nxt;
  logic hit_r, hit_nxt;
  otaq_pkg::entry_t res_r, res_nxt;
  logic [31:0] oh_r, oh_nxt;

  logic we;
  logic [IW-1:0] waddr, raddr;
  otaq_pkg::entry_t wdata, rdata, in_ent;
  logic h_eq, ovl;

  assign in_ent = '{handle: in_handle, kind: in_kind, solid: in_solid,
                    pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z,
                    size_x: in_size_x, size_y: in_size_y, size_z: in_size_z};

  otaq_mem u_mem (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                  .raddr(raddr), .rdata(rdata));
  otaq_match u_match (.ent(rdata), .req(req_r), .handle_eq(h_eq), .overlap(ovl));

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    next_h_nxt = next_h_r;
    ptr_nxt = ptr_r;
    slot_nxt = slot_r;
    st_nxt = st_r;
    hit_nxt = hit_r;
    res_nxt = res_r;
    oh_nxt = oh_r;
    we = 1'b0;
    waddr = used_r[IW-1:0];
    wdata = in_ent;
    raddr = ptr_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt = otaq_pkg::ST_OK;
          hit_nxt = 1'b0;
          res_nxt = '0;
          oh_nxt = in_handle;
          ptr_nxt = '0;
          raddr = '0;
          if (in_req_type == otaq_pkg::REQ_SPAWN) begin
            if (used_r == CW'(otaq_pkg::Capacity)) begin
              st_nxt = otaq_pkg::ST_FULL;
            end else begin
              we = 1'b1;
              wdata.handle = next_h_r;
              oh_nxt = next_h_r;
              next_h_nxt = next_h_r + 32'd1;
              used_nxt = used_r + CW'(1);
            end
            state_nxt = S_OUT;
          end else if (used_r == '0) begin
            if (in_req_type != otaq_pkg::REQ_QUERY) st_nxt = otaq_pkg::ST_MISS;
            state_nxt = S_OUT;
          end else begin
            ptr_nxt = CW'(1);
            slot_nxt = '0;
            state_nxt = S_TEST;
          end
        end
      end
      S_SCAN: begin
        // read issued at ptr, wait for registered data
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (type_r == otaq_pkg::REQ_QUERY && ovl) begin
          hit_nxt = 1'b1;
          state_nxt = S_OUT;
        end else if (type_r != otaq_pkg::REQ_QUERY && h_eq) begin
          if (type_r == otaq_pkg::REQ_LOOKUP) begin
            res_nxt = rdata;
            state_nxt = S_OUT;
          end else begin
            ptr_nxt = used_r - CW'(1);
            raddr = ptr_nxt[IW-1:0];
            state_nxt = S_MOVE;
          end
        end else if (ptr_r == used_r) begin
          if (type_r != otaq_pkg::REQ_QUERY) st_nxt = otaq_pkg::ST_MISS;
          state_nxt = S_OUT;
        end else begin
          // read the row that becomes the tested slot next cycle
          slot_nxt = ptr_r[IW-1:0];
          ptr_nxt = ptr_r + CW'(1);
          raddr = ptr_r[IW-1:0];
          state_nxt = S_TEST;
        end
      end
      S_MOVE: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        // last row now at rdata, copy into the killed slot
        we = 1'b1;
        waddr = slot_r;
        wdata = rdata;
        used_nxt = used_r - CW'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      next_h_r <= 32'd1;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      next_h_r <= next_h_nxt;
    end
    ptr_r <= ptr_nxt;
    slot_r <= slot_nxt;
    st_r <= st_nxt;
    hit_r <= hit_nxt;
    res_r <= res_nxt;
    oh_r <= oh_nxt;
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_ent;
      type_r <= in_req_type;
    end
  end

  // result fields
  assign out_status = st_r;
  assign out_out_handle = oh_r;
  assign out_hit = hit_r;
  assign out_out_kind = res_r.kind;
  assign out_out_solid = res_r.solid;
  assign out_out_pos_x = res_r.pos_x;
  assign out_out_pos_y = res_r.pos_y;
  assign out_out_pos_z = res_r.pos_z;
  assign out_out_size_x = res_r.size_x;
  assign out_out_size_y = res_r.size_y;
  assign out_out_size_z = res_r.size_z;
  assign out_live_count = 7'(used_r);
endmodule

/* rtl/otaq_checker.sv */
// port-level checker for the object table, bound to the top level
// depends on object_table_with_aabb_query_unit_defines.svh and otaq_pkg
`include "object_table_with_aabb_query_unit_defines.svh"
module otaq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic       out_hit,
  input logic [6:0] out_live_count
);
  `OT_ASSERT_IMP(a_busy_stall, clk, rst_n, out_valid, in_stall)
  `OT_ASSERT_IMP(a_live_range, clk, rst_n, out_valid, out_live_count <= 7'(otaq_pkg::Capacity))
  `OT_ASSERT_IMP(a_hit_ok, clk, rst_n, out_valid && out_hit, out_status == otaq_pkg::ST_OK)
  `OT_ASSERT_NXT(a_take_stall, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind object_table_with_aabb_query_unit otaq_checker u_otaq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_hit(out_hit), .out_live_count(out_live_count)
);
